FILE: src/rpn_pkg.sv
// Shared types and constants for the RPN stack calculator.
// Holds stack sizing, op and status codes, sequencer states and the word structs.
// No dependencies.
package rpn_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int ITER_W      = $clog2(DATA_W);

	// op codes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_DIV0  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [30:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic               top_valid;
		logic [6:0]         depth;
		logic [1:0]         status;
	} rsp_t;

endpackage

FILE: src/rpn_stack_calculator.sv
// RPN stack calculator: stack memory, cached top entry and a sequencer that drives
// one shared adder/subtractor for add, subtract, shift-add multiply and restoring divide.
// Depends on rpn_pkg.
//
//  channel | signals                 | direction | word
//  --------+-------------------------+-----------+--------------------------------
//  req     | req_valid, req_stall    | in        | op, value
//  rsp     | rsp_valid, rsp_stall    | out       | top_value, top_valid, depth, status
//
// One word is taken at a time; req_stall is high from acceptance until its result is
// loaded into the rsp register. Push, underflow and ignored codes go from dispatch straight
// to done; add, subtract and divide by zero pass through execute; multiply and divide run
// 32 single-bit steps through the shared adder after execute.
// Reset clears the sequencer, the entry count and rsp_valid; stack memory is not cleared.
// A stalled rsp holds the block in its final state until the result register frees up.
module rpn_stack_calculator
	import rpn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// stack body below the top entry; top lives in top_q
	logic [DATA_W-1:0] mem_q [STACK_DEPTH];
	logic [DATA_W-1:0] rd_q;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] top_q;
	logic [2:0]        op_q;
	logic [30:0]       val_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] acc_q;    // product accumulator / division remainder
	logic [DATA_W-1:0] mq_q;     // multiplier / dividend-quotient
	logic [DATA_W-1:0] opb_q;    // shifted multiplicand / divisor magnitude
	logic              neg_q;
	logic [ITER_W-1:0] iter_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              stack_full;
	logic              rsp_free;
	logic              iter_last;

	// shared adder/subtractor
	logic [DATA_W:0]   alu_x, alu_y;
	logic              alu_sub;
	logic [DATA_W+1:0] alu_sum;

	assign rd_addr    = ADDR_W'(count_q - CNT_W'(2));
	assign wr_addr    = ADDR_W'(count_q - CNT_W'(1));
	assign stack_full = (count_q == CNT_W'(STACK_DEPTH));
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign iter_last  = (iter_q == ITER_W'(DATA_W - 1));
	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// operand select for the shared unit
	always_comb begin
		alu_x   = {1'b0, rd_q};
		alu_y   = {1'b0, top_q};
		alu_sub = (op_q == OP_SUB);
		case (state_q)
			S_MUL: begin
				alu_x   = {1'b0, acc_q};
				alu_y   = {1'b0, opb_q};
				alu_sub = 1'b0;
			end
			S_DIV: begin
				alu_x   = {acc_q, mq_q[DATA_W-1]};
				alu_y   = {1'b0, opb_q};
				alu_sub = 1'b1;
			end
			default: ;
		endcase
		alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
			+ (DATA_W+2)'(alu_sub);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (req_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (op_q == OP_PUSH || op_q > OP_DIV || count_q < CNT_W'(2))
					state_d = S_DONE;
				else
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (op_q == OP_MUL)
					state_d = S_MUL;
				else if (op_q == OP_DIV && top_q != '0)
					state_d = S_DIV;
				else
					state_d = S_DONE;
			end
			S_MUL:  if (iter_last) state_d = S_DONE;
			S_DIV:  if (iter_last) state_d = S_DONE;
			S_DONE: if (rsp_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// stack memory: registered read of the second entry, write on push
	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
		if (state_q == S_DISPATCH && op_q == OP_PUSH && !stack_full && count_q != '0)
			mem_q[wr_addr] <= top_q;
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (state_q == S_DISPATCH && op_q == OP_PUSH && !stack_full)
				count_q <= count_q + CNT_W'(1);
			else if ((state_q == S_EXEC && (op_q == OP_ADD || op_q == OP_SUB))
				|| ((state_q == S_MUL || state_q == S_DIV) && iter_last))
				count_q <= count_q - CNT_W'(1);
		end
	end

	// datapath and sequencing registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= req.op;
				val_q    <= req.value;
				status_q <= ST_OK;
			end
			S_DISPATCH: begin
				if (op_q == OP_PUSH) begin
					if (stack_full)
						status_q <= ST_FULL;
					else
						top_q <= {1'b0, val_q};
				end else if (op_q <= OP_DIV && count_q < CNT_W'(2)) begin
					status_q <= ST_UNDER;
				end
			end
			S_EXEC: begin
				iter_q <= '0;
				acc_q  <= '0;
				case (op_q)
					OP_ADD, OP_SUB: top_q <= alu_sum[DATA_W-1:0];
					OP_MUL: begin
						mq_q  <= top_q;
						opb_q <= rd_q;
					end
					OP_DIV: begin
						if (top_q == '0)
							status_q <= ST_DIV0;
						mq_q  <= rd_q[DATA_W-1] ? -rd_q : rd_q;
						opb_q <= top_q[DATA_W-1] ? -top_q : top_q;
						neg_q <= rd_q[DATA_W-1] ^ top_q[DATA_W-1];
					end
					default: ;
				endcase
			end
			S_MUL: begin
				iter_q <= iter_q + ITER_W'(1);
				if (mq_q[0])
					acc_q <= alu_sum[DATA_W-1:0];
				mq_q  <= mq_q >> 1;
				opb_q <= opb_q << 1;
				if (iter_last)
					top_q <= mq_q[0] ? alu_sum[DATA_W-1:0] : acc_q;
			end
			S_DIV: begin : div_step
				logic [DATA_W-1:0] q_next;
				q_next = {mq_q[DATA_W-2:0], alu_sum[DATA_W+1]};
				iter_q <= iter_q + ITER_W'(1);
				mq_q   <= q_next;
				acc_q  <= alu_sum[DATA_W+1] ? alu_sum[DATA_W-1:0] : alu_x[DATA_W-1:0];
				if (iter_last)
					top_q <= neg_q ? -q_next : q_next;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			rsp_q.top_value <= (count_q != '0) ? top_q : '0;
			rsp_q.top_valid <= (count_q != '0);
			rsp_q.depth     <= 7'(count_q);
			rsp_q.status    <= status_q;
		end
	end

endmodule

FILE: tb/rpn_checker.sv
// Checker for the RPN stack calculator: watches the req and rsp channels, predicts each result
// word from its own copy of the stack and compares field by field.
// Depends on rpn_pkg.
module rpn_checker import rpn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the calculator stack
	logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
	int                shadow_count = 0;

	rsp_t expected_rsps[$];
	int   fail_count = 0;
	int   pending_count = 0;

	assign mismatches  = fail_count;
	assign outstanding = pending_count;

	// apply one token to the shadow stack and return the word the block should report
	function automatic rsp_t evaluate_token(input req_t w);
		rsp_t              r;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic [DATA_W-1:0] res;
		logic              done;
		r      = '0;
		done   = 1'b1;
		res    = '0;
		r.status = ST_OK;
		if (w.op == OP_PUSH) begin
			if (shadow_count >= STACK_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_stack[shadow_count] = {1'b0, w.value};
				shadow_count++;
			end
		end else if (w.op <= OP_DIV) begin
			if (shadow_count < 2) begin
				r.status = ST_UNDER;
			end else begin
				rhs = shadow_stack[shadow_count - 1];
				lhs = shadow_stack[shadow_count - 2];
				case (w.op)
					OP_ADD: res = lhs + rhs;
					OP_SUB: res = lhs - rhs;
					OP_MUL: res = lhs * rhs;
					default: begin
						if (rhs == '0) begin
							done     = 1'b0;
							r.status = ST_DIV0;
						end else if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF) begin
							// most negative over minus one wraps back to itself
							res = lhs;
						end else begin
							res = $signed(lhs) / $signed(rhs);
						end
					end
				endcase
				if (done) begin
					shadow_stack[shadow_count - 2] = res;
					shadow_count--;
				end
			end
		end
		// codes above divide leave everything alone
		if (shadow_count > 0) begin
			r.top_value = shadow_stack[shadow_count - 1];
			r.top_valid = 1'b1;
		end
		r.depth = shadow_count[6:0];
		return r;
	endfunction

	// compare accepted results, then record the expectation for an accepted token
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			shadow_count = 0;
			expected_rsps.delete();
			pending_count = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$error("rsp word with no result expected");
					fail_count++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.top_value !== want.top_value) begin
						$error("top_value: expected %0d, got %0d", want.top_value,
							rsp.top_value);
						fail_count++;
					end
					if (rsp.top_valid !== want.top_valid) begin
						$error("top_valid: expected %0d, got %0d", want.top_valid,
							rsp.top_valid);
						fail_count++;
					end
					if (rsp.depth !== want.depth) begin
						$error("depth: expected %0d, got %0d", want.depth, rsp.depth);
						fail_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsps.push_back(evaluate_token(req));
			pending_count = expected_rsps.size();
		end
	end

endmodule

FILE: tb/rpn_stack_calculator_test.sv
// Top of the RPN stack calculator testbench: clock, reset, token stimulus and rsp back-pressure.
// Depends on rpn_pkg, rpn_stack_calculator and rpn_checker.
module rpn_stack_calculator_test import rpn_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// op codes the block ignores
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	localparam int TOKEN_GOAL = 900;
	localparam int QUIET_TAIL = 800;
	localparam int HOLD_AT    = 250;
	localparam int HOLD_LEN   = 300;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   mismatches;
	int   outstanding;

	int   idle_odds = 0;   // 0: no idling, else one chance in idle_odds
	bit   long_hold = 1'b0;
	int   est_depth = 0;   // rough depth, only to steer stimulus
	int   tokens_sent = 0;

	rpn_stack_calculator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	rpn_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one token word, with an optional gap first, and wait for it to be taken
	task automatic send_token(input logic [2:0] op, input logic [30:0] value);
		req_t w;
		w.op    = op;
		w.value = value;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
		@(negedge clk);
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		tokens_sent++;
		if (op == OP_PUSH) begin
			if (est_depth < STACK_DEPTH)
				est_depth++;
		end else if (op <= OP_DIV && est_depth >= 2) begin
			est_depth--;
		end
	endtask

	// push values lean on the edges: zero, the maximum and small numbers
	function automatic logic [30:0] pick_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 31'h7FFF_FFFF;
			2, 3: return 31'($urandom_range(0, 15));
			default: return 31'($urandom);
		endcase
	endfunction

	// rsp back-pressure: random bursts, plus one long hold-off
	initial begin
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				long_hold = 1'b0;
				rsp_stall <= 1'b0;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int  block_seen;
		bit  hold_done;
		int  odds_pick;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		block_seen = -1;
		hold_done  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: underflow on empty and single entry, wrap to the most negative value,
		// most negative over minus one, divide by zero, ignored codes, truncation toward zero
		idle_odds = 4;
		send_token(OP_ADD, '0);
		send_token(OP_DIV, 31'h7FFF_FFFF);
		send_token(OP_PUSH, 31'h7FFF_FFFF);
		send_token(OP_SUB, '0);
		send_token(OP_PUSH, 31'd1);
		send_token(OP_ADD, 31'h5555_5555);
		send_token(OP_PUSH, '0);
		send_token(OP_PUSH, 31'd1);
		send_token(OP_SUB, '0);
		send_token(OP_DIV, '0);
		send_token(OP_PUSH, '0);
		send_token(OP_DIV, '0);
		send_token(OP_RSVD5, 31'($urandom));
		send_token(OP_RSVD6, 31'($urandom));
		send_token(OP_RSVD7, 31'($urandom));
		send_token(OP_MUL, '0);
		send_token(OP_PUSH, '0);
		send_token(OP_PUSH, 31'd7);
		send_token(OP_SUB, '0);
		send_token(OP_PUSH, 31'd2);
		send_token(OP_DIV, '0);
		send_token(OP_MUL, '0);

		// random: mostly well-formed expressions, sometimes a fill past full, some noise
		while (tokens_sent < TOKEN_GOAL) begin
			if (tokens_sent >= QUIET_TAIL) begin
				idle_odds = 0;
			end else if (tokens_sent / 100 != block_seen) begin
				block_seen = tokens_sent / 100;
				odds_pick  = $urandom_range(0, 2);
				idle_odds  = (odds_pick == 0) ? 0 : (odds_pick == 1) ? 4 : 12;
			end
			if (tokens_sent >= HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				long_hold = 1'b1;
			end
			case ($urandom_range(0, 29))
				0: begin
					while (est_depth < STACK_DEPTH)
						send_token(OP_PUSH, pick_value());
					repeat ($urandom_range(1, 3)) send_token(OP_PUSH, pick_value());
					while (est_depth > 2)
						send_token(3'($urandom_range(OP_ADD, OP_DIV)), 31'($urandom));
				end
				1, 2, 3: begin
					repeat ($urandom_range(1, 8))
						send_token(3'($urandom_range(0, 7)), 31'($urandom));
				end
				default: begin
					repeat ($urandom_range(4, 20)) begin
						if (est_depth < 2 ||
							(est_depth < STACK_DEPTH && $urandom_range(0, 2) == 0))
							send_token(OP_PUSH, pick_value());
						else
							send_token(3'($urandom_range(OP_ADD, OP_DIV)), 31'($urandom));
					end
				end
			endcase
		end
		@(negedge clk);
		req_valid <= 1'b0;

		// drain, then allow for the longest op
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
